### hw/rtl/pdcp_rrw_pkg.sv
// ----------------------------------------------------------------------------
// PDCP receive reordering window package
// Shared item types, result kinds, register indexes and sizes.
// ----------------------------------------------------------------------------
package pdcp_rrw_pkg;

  // Reorder buffer size and stored handle width.
  localparam int BufferDepth = 64;
  localparam int HandleBits  = 16;
  localparam int SlotBits    = $clog2(BufferDepth);
  localparam int MaxResults  = 64;
  localparam int ResCntBits  = $clog2(MaxResults + 1);
  localparam int ScanBits    = $clog2(BufferDepth + 1);

  // Result kinds.
  localparam logic [2:0] KIND_DELIVER   = 3'd0;
  localparam logic [2:0] KIND_STORED    = 3'd1;
  localparam logic [2:0] KIND_SHORT     = 3'd2;
  localparam logic [2:0] KIND_OVERFLOW  = 3'd3;
  localparam logic [2:0] KIND_INTEGRITY = 3'd4;
  localparam logic [2:0] KIND_STALE     = 3'd5;
  localparam logic [2:0] KIND_DUPLICATE = 3'd6;
  localparam logic [2:0] KIND_NO_ROOM   = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_SN_LENGTH       = 3'd0;
  localparam logic [2:0] REG_HEADER_BYTES    = 3'd1;
  localparam logic [2:0] REG_INTEGRITY_CHECK = 3'd2;
  localparam logic [2:0] REG_REORDER_ENABLE  = 3'd3;
  localparam logic [2:0] REG_REORDER_TICKS   = 3'd4;

  // Input function codes.
  localparam logic FUNC_PDU  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic        func;
    logic [17:0] seq_num;
    logic [13:0] pdu_bytes;
    logic        integrity_ok;
    logic [15:0] buffer_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] count_value;
    logic [15:0] handle_out;
    logic        last;
  } out_item_t;

  // Access request to the slot store.
  typedef struct packed {
    logic [SlotBits-1:0]   addr;
    logic                  set_vld;
    logic                  clr_vld;
    logic                  rd_en;
    logic [HandleBits-1:0] wdata;
  } slot_req_t;

  // Control from the sequencer to the output stage.
  typedef struct packed {
    logic                  push;
    logic                  fin;
    logic [2:0]            kind;
    logic [31:0]           count;
    logic [HandleBits-1:0] handle;
  } res_ctl_t;

  // Status from the output stage back to the sequencer.
  typedef struct packed {
    logic push_ok;
    logic fin_done;
    logic hold_v;
  } res_sts_t;

endpackage

### hw/rtl/pdcp_rrw_slot_mem.sv
// ----------------------------------------------------------------------------
// PDCP reorder slot store
// Per-slot valid flags in flip-flops and a handle memory with registered read.
// ----------------------------------------------------------------------------
module pdcp_rrw_slot_mem
  import pdcp_rrw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  slot_req_t             req,
  output logic                  vld,
  output logic [HandleBits-1:0] rdata
);

  logic [BufferDepth-1:0] vld_r;
  logic [HandleBits-1:0]  mem [BufferDepth];
  logic [HandleBits-1:0]  rdata_r;

  assign vld   = vld_r[req.addr];
  assign rdata = rdata_r;

  // Valid flags are cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.set_vld) begin
      vld_r[req.addr] <= 1'b1;
    end else if (req.clr_vld) begin
      vld_r[req.addr] <= 1'b0;
    end
  end

  // Handle memory: a slot is written when it becomes valid.
  always_ff @(posedge clk) begin
    if (req.set_vld) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

endmodule

### hw/rtl/pdcp_rrw_out_stage.sv
// ----------------------------------------------------------------------------
// PDCP reorder result stage
// Holds one result back so the final one of an item can be marked last.
// ----------------------------------------------------------------------------
module pdcp_rrw_out_stage
  import pdcp_rrw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_ctl_t  ctl,
  output res_sts_t  sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t hold_r;
  logic      hold_v_r;
  out_item_t out_r;
  logic      out_v_r;
  logic      can_move;
  logic      move;

  assign can_move     = !out_v_r || out_ready;
  assign sts.push_ok  = !hold_v_r || can_move;
  assign sts.fin_done = !hold_v_r || can_move;
  assign sts.hold_v   = hold_v_r;
  assign move         = hold_v_r && can_move && (ctl.push || ctl.fin);
  assign out_valid    = out_v_r;
  assign out_data     = out_r;

  // The held result moves out, marked last when the item finishes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (ctl.push && sts.push_ok) begin
        hold_v_r <= 1'b1;
      end else if (ctl.fin && sts.fin_done) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= '{kind: hold_r.kind, count_value: hold_r.count_value,
                 handle_out: hold_r.handle_out, last: ctl.fin};
    end
    if (ctl.push && sts.push_ok) begin
      hold_r <= '{kind: ctl.kind, count_value: ctl.count,
                  handle_out: 16'(ctl.handle), last: 1'b0};
    end
  end

endmodule

### hw/rtl/pdcp_nr_rx_reorder_window_top.sv
// ----------------------------------------------------------------------------
// PDCP NR receive reordering window
// Top level: COUNT estimation, checks, reorder sequencer and t-Reordering.
// ----------------------------------------------------------------------------
// After an item is accepted, a dropped PDU passes through COUNT estimate,
// checks and finish, and a stored PDU also through the timer update before
// the finish. A PDU that completes an in-order run adds a step to find the
// end of the run and, for each delivered PDU, a slot memory read, then its
// result. A tick that does not expire the timer is done in its accept cycle.
// An expiry scans the slots below the reordering point one per cycle, up to
// 64, while no slot needs flushing; each flushed PDU adds a result step. It
// then closes the scan, walks the run that follows with a read and a result
// per PDU, finds the end of the run and finishes. Results leave through a
// holding register, so a stalled consumer also stalls the sequencer. One
// item is worked on at a time.
module pdcp_nr_rx_reorder_window_top
  import pdcp_rrw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ARR  = 9'b000000010,
    ST_CHK  = 9'b000000100,
    ST_RD   = 9'b000001000,
    ST_DLV  = 9'b000010000,
    ST_EXP  = 9'b000100000,
    ST_EXD  = 9'b001000000,
    ST_TMR  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;

  // Configuration registers.
  logic [4:0]  sn_len_r;
  logic [1:0]  hdr_r;
  logic        integ_r;
  logic        reord_en_r;
  logic [15:0] ticks_r;

  // Window state.
  logic [31:0] next_r, next_nxt;
  logic [31:0] deliv_r, deliv_nxt;
  logic [31:0] reord_r, reord_nxt;
  logic        ovf_r, ovf_nxt;
  logic        run_r, run_nxt;
  logic [15:0] left_r, left_nxt;

  // Per-item working registers.
  in_item_t        item_r;
  logic [31:0]     cnt_r, cnt_nxt;
  logic [ScanBits-1:0] off_r, off_nxt;
  logic            from_exp_r, from_exp_nxt;
  logic [ResCntBits-1:0] nres_r, nres_nxt;

  slot_req_t             req;
  logic                  slot_vld;
  logic [HandleBits-1:0] slot_rdata;
  res_ctl_t              rctl;
  res_sts_t              rsts;

  // COUNT estimate for both SN lengths.
  logic        sn18;
  logic [11:0] rsn12, dsn12;
  logic [19:0] hfn12;
  logic [17:0] rsn18, dsn18;
  logic [13:0] hfn18;
  logic        up12, dn12, up18, dn18;
  logic [31:0] est12, est18;

  // Helpers for checks and timer.
  logic [31:0] diff;
  logic [32:0] scan_c;
  logic [15:0] dur;
  logic        run_after;
  logic        emit_ok;

  pdcp_rrw_slot_mem u_slot (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .vld   (slot_vld),
    .rdata (slot_rdata)
  );

  pdcp_rrw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rctl),
    .sts       (rsts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = (st_r == ST_IDLE);

  assign sn18  = (sn_len_r == 5'd18);
  assign rsn12 = item_r.seq_num[11:0];
  assign dsn12 = deliv_r[11:0];
  assign hfn12 = deliv_r[31:12];
  assign rsn18 = item_r.seq_num;
  assign dsn18 = deliv_r[17:0];
  assign hfn18 = deliv_r[31:18];
  assign up12  = dsn12[11] && (rsn12 < (dsn12 - 12'd2048));
  assign dn12  = ({1'b0, rsn12} >= ({1'b0, dsn12} + 13'd2048));
  assign up18  = dsn18[17] && (rsn18 < (dsn18 - 18'd131072));
  assign dn18  = ({1'b0, rsn18} >= ({1'b0, dsn18} + 19'd131072));
  assign est12 = {up12 ? hfn12 + 20'd1 : (dn12 ? hfn12 - 20'd1 : hfn12), rsn12};
  assign est18 = {up18 ? hfn18 + 14'd1 : (dn18 ? hfn18 - 14'd1 : hfn18), rsn18};

  assign diff      = cnt_r - deliv_r;
  assign scan_c    = {1'b0, deliv_r} + 33'(off_r);
  assign dur       = (ticks_r == 16'd0) ? 16'd1 : ticks_r;
  assign run_after = run_r && !(deliv_r >= reord_r);
  assign emit_ok   = rsts.push_ok;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sn_len_r   <= 5'd12;
      hdr_r      <= 2'd2;
      integ_r    <= 1'b0;
      reord_en_r <= 1'b0;
      ticks_r    <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SN_LENGTH:       sn_len_r   <= cfg_wdata[4:0];
        REG_HEADER_BYTES:    hdr_r      <= cfg_wdata[1:0];
        REG_INTEGRITY_CHECK: integ_r    <= cfg_wdata[0];
        REG_REORDER_ENABLE:  reord_en_r <= cfg_wdata[0];
        REG_REORDER_TICKS:   ticks_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    st_nxt       = st_r;
    next_nxt     = next_r;
    deliv_nxt    = deliv_r;
    reord_nxt    = reord_r;
    ovf_nxt      = ovf_r;
    run_nxt      = run_r;
    left_nxt     = left_r;
    cnt_nxt      = cnt_r;
    off_nxt      = off_r;
    from_exp_nxt = from_exp_r;
    nres_nxt     = nres_r;
    req          = '0;
    req.wdata    = item_r.buffer_handle[HandleBits-1:0];
    rctl         = '0;
    rctl.count   = cnt_r;
    rctl.handle  = item_r.buffer_handle[HandleBits-1:0];
    unique case (st_r)
      ST_IDLE: begin
        nres_nxt = '0;
        if (in_valid) begin
          if (in_data.func == FUNC_PDU) begin
            st_nxt = ST_ARR;
          end else if (run_r) begin
            left_nxt = (left_r != 16'd0) ? left_r - 16'd1 : 16'd0;
            if (left_nxt == 16'd0) begin
              run_nxt = 1'b0;
              off_nxt = '0;
              st_nxt  = ST_EXP;
            end
          end
        end
      end
      ST_ARR: begin
        cnt_nxt = sn18 ? est18 : est12;
        st_nxt  = ST_CHK;
      end
      ST_CHK: begin
        req.addr = cnt_r[SlotBits-1:0];
        rctl.kind = KIND_STORED;
        if (ovf_r) begin
          rctl.kind = KIND_OVERFLOW;
        end else if (item_r.pdu_bytes <= 14'(hdr_r)) begin
          rctl.kind = KIND_SHORT;
        end else if (integ_r && !item_r.integrity_ok) begin
          rctl.kind = KIND_INTEGRITY;
        end else if (cnt_r < deliv_r) begin
          rctl.kind = KIND_STALE;
        end else if (diff >= 32'(BufferDepth)) begin
          rctl.kind = KIND_NO_ROOM;
        end else if (slot_vld) begin
          rctl.kind = KIND_DUPLICATE;
        end
        if (emit_ok) begin
          if (rctl.kind == KIND_STORED) begin
            req.set_vld = 1'b1;
            if (cnt_r >= next_r) begin
              next_nxt = cnt_r + 32'd1;
            end
            if (cnt_r == deliv_r) begin
              from_exp_nxt = 1'b0;
              st_nxt       = ST_RD;
            end else begin
              rctl.push = (nres_r < ResCntBits'(MaxResults));
              nres_nxt  = nres_r + ResCntBits'(rctl.push);
              st_nxt    = ST_TMR;
            end
          end else begin
            rctl.push = (nres_r < ResCntBits'(MaxResults));
            nres_nxt  = nres_r + ResCntBits'(rctl.push);
            st_nxt    = ST_FIN;
          end
        end
      end
      ST_RD: begin
        // Consecutive run from the delivery point.
        req.addr = deliv_r[SlotBits-1:0];
        if (slot_vld && !ovf_r) begin
          req.rd_en   = 1'b1;
          req.clr_vld = 1'b1;
          cnt_nxt     = deliv_r;
          if (deliv_r == 32'hFFFF_FFFF) begin
            ovf_nxt = 1'b1;
          end
          deliv_nxt = deliv_r + 32'd1;
          st_nxt    = ST_DLV;
        end else if (from_exp_r) begin
          if (deliv_r < next_r) begin
            reord_nxt = next_r;
            run_nxt   = 1'b1;
            left_nxt  = dur;
          end
          st_nxt = ST_FIN;
        end else begin
          st_nxt = ST_TMR;
        end
      end
      ST_DLV, ST_EXD: begin
        rctl.kind   = KIND_DELIVER;
        rctl.handle = slot_rdata;
        if (emit_ok) begin
          rctl.push = (nres_r < ResCntBits'(MaxResults));
          nres_nxt  = nres_r + ResCntBits'(rctl.push);
          if (st_r == ST_DLV) begin
            st_nxt = ST_RD;
          end else begin
            off_nxt = off_r + ScanBits'(1);
            st_nxt  = ST_EXP;
          end
        end
      end
      ST_EXP: begin
        // Flush every stored PDU below the reordering point.
        req.addr = scan_c[SlotBits-1:0];
        if (off_r == ScanBits'(BufferDepth) || scan_c[32] || scan_c[31:0] >= reord_r) begin
          if (reord_r >= deliv_r) begin
            deliv_nxt = reord_r;
          end
          from_exp_nxt = 1'b1;
          st_nxt       = ST_RD;
        end else if (slot_vld) begin
          req.rd_en   = 1'b1;
          req.clr_vld = 1'b1;
          cnt_nxt     = scan_c[31:0];
          st_nxt      = ST_EXD;
        end else begin
          off_nxt = off_r + ScanBits'(1);
        end
      end
      ST_TMR: begin
        run_nxt = run_after;
        if (reord_en_r && !run_after && deliv_r < next_r) begin
          reord_nxt = next_r;
          run_nxt   = 1'b1;
          left_nxt  = dur;
        end
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        rctl.fin = 1'b1;
        if (rsts.fin_done) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control and window state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      next_r     <= '0;
      deliv_r    <= '0;
      reord_r    <= '0;
      ovf_r      <= 1'b0;
      run_r      <= 1'b0;
      left_r     <= '0;
      nres_r     <= '0;
      off_r      <= '0;
      from_exp_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      next_r     <= next_nxt;
      deliv_r    <= deliv_nxt;
      reord_r    <= reord_nxt;
      ovf_r      <= ovf_nxt;
      run_r      <= run_nxt;
      left_r     <= left_nxt;
      nres_r     <= nres_nxt;
      off_r      <= off_nxt;
      from_exp_r <= from_exp_nxt;
    end
  end

  // Item payload and working COUNT.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    cnt_r <= cnt_nxt;
  end

  // A new item is only taken once no result is held back in the result stage.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !rsts.hold_v)
    else $error("result held while idle");

  // Once COUNT has overflowed it stays overflowed.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag dropped");

  // A running timer always has time left.
  a_timer_left: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (left_r != 16'd0))
    else $error("timer running with no time left");

  // The result count never passes the cap.
  a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= ResCntBits'(MaxResults))
    else $error("result count beyond cap");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// PDCP NR receive reordering window testbench
// Drives PDU and tick items through the block under several register
// settings and checks every result against an in-bench window predictor.
// ----------------------------------------------------------------------------
module tb;
  import pdcp_rrw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  pdcp_nr_rx_reorder_window_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Register copies held by the predictor.
  logic [4:0]  sn_len_q;
  logic [1:0]  hdr_bytes_q;
  logic        integ_chk_q;
  logic        reord_en_q;
  logic [15:0] reord_ticks_q;

  // Window state of the predictor.
  logic [31:0]     rx_next;
  logic [31:0]     win_deliv;
  logic [31:0]     win_reord;
  bit              wrapped;
  bit              t_running;
  int unsigned     t_left;
  bit              slot_full [BufferDepth];
  logic [15:0]     slot_hdl [BufferDepth];
  int              item_results;

  out_item_t expected_results[$];
  int        mismatches;
  int        cycles;
  bit        idle_on;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Queue one expected result, honoring the per-item cap.
  task automatic add_result(logic [2:0] kind, logic [31:0] cnt, logic [15:0] hdl);
    out_item_t r;
    if (item_results < MaxResults) begin
      r.kind = kind;
      r.count_value = cnt;
      r.handle_out = hdl;
      r.last = 1'b0;
      expected_results.push_back(r);
      item_results++;
    end
  endtask

  task automatic arm_timer();
    win_reord = rx_next;
    t_running = 1'b1;
    t_left = (reord_ticks_q == 16'd0) ? 1 : reord_ticks_q;
  endtask

  // Deliver the consecutive run starting at win_deliv.
  task automatic deliver_in_order();
    logic [5:0] idx;
    for (int k = 0; k < BufferDepth; k++) begin
      idx = win_deliv[5:0];
      if (!slot_full[idx] || wrapped) break;
      if (win_deliv == 32'hFFFF_FFFF) wrapped = 1'b1;
      add_result(KIND_DELIVER, win_deliv, slot_hdl[idx]);
      slot_full[idx] = 1'b0;
      win_deliv = win_deliv + 32'd1;
    end
  endtask

  // t-Reordering expiry: flush below win_reord, then the run from there.
  task automatic timer_expiry();
    logic [31:0] c;
    for (int o = 0; o < BufferDepth; o++) begin
      c = win_deliv + o;
      if (c < win_deliv || c >= win_reord) break;
      if (slot_full[c[5:0]]) begin
        add_result(KIND_DELIVER, c, slot_hdl[c[5:0]]);
        slot_full[c[5:0]] = 1'b0;
      end
    end
    if (win_reord >= win_deliv) win_deliv = win_reord;
    deliver_in_order();
    if (win_deliv < rx_next) arm_timer();
  endtask

  // PDU arrival: COUNT estimate, drop checks, store and deliver.
  task automatic pdu_arrival(in_item_t it);
    int          bits;
    logic [31:0] mask;
    longint      win;
    logic [31:0] rsn;
    logic [31:0] dsn;
    logic [31:0] dhfn;
    logic [31:0] hfn;
    logic [31:0] cnt;
    logic [63:0] wide;
    bits = (sn_len_q == 5'd18) ? 18 : 12;
    mask = (32'd1 << bits) - 32'd1;
    win = longint'(1) << (bits - 1);
    rsn = {14'd0, it.seq_num} & mask;
    dsn = win_deliv & mask;
    dhfn = win_deliv >> bits;
    if (longint'(rsn) < longint'(dsn) - win) hfn = dhfn + 32'd1;
    else if (longint'(rsn) >= longint'(dsn) + win) hfn = dhfn - 32'd1;
    else hfn = dhfn;
    wide = {32'd0, hfn} << bits;
    cnt = wide[31:0] | rsn;
    if (wrapped) add_result(KIND_OVERFLOW, cnt, it.buffer_handle);
    else if (it.pdu_bytes <= {12'd0, hdr_bytes_q}) add_result(KIND_SHORT, cnt, it.buffer_handle);
    else if (integ_chk_q && !it.integrity_ok)
      add_result(KIND_INTEGRITY, cnt, it.buffer_handle);
    else if (cnt < win_deliv) add_result(KIND_STALE, cnt, it.buffer_handle);
    else if (cnt - win_deliv >= BufferDepth) add_result(KIND_NO_ROOM, cnt, it.buffer_handle);
    else if (slot_full[cnt[5:0]]) add_result(KIND_DUPLICATE, cnt, it.buffer_handle);
    else begin
      slot_full[cnt[5:0]] = 1'b1;
      slot_hdl[cnt[5:0]] = it.buffer_handle;
      if (cnt >= rx_next) rx_next = cnt + 32'd1;
      if (cnt == win_deliv) deliver_in_order();
      else add_result(KIND_STORED, cnt, it.buffer_handle);
      if (t_running && win_deliv >= win_reord) t_running = 1'b0;
      if (reord_en_q && !t_running && win_deliv < rx_next) arm_timer();
    end
  endtask

  // Work out every result that one accepted item causes.
  task automatic predict_item(in_item_t it);
    item_results = 0;
    if (it.func == FUNC_PDU) begin
      pdu_arrival(it);
    end else if (t_running) begin
      if (t_left > 0) t_left--;
      if (t_left == 0) begin
        t_running = 1'b0;
        timer_expiry();
      end
    end
    if (item_results > 0) expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  // Send one item; called and returning at a falling edge.
  task automatic send_item(in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    @(negedge clk);
  endtask

  function automatic in_item_t make_pdu(int sn, int bytes, bit ok, int hdl);
    in_item_t it;
    it.func = FUNC_PDU;
    it.seq_num = sn[17:0];
    it.pdu_bytes = bytes[13:0];
    it.integrity_ok = ok;
    it.buffer_handle = hdl[15:0];
    return it;
  endfunction

  function automatic in_item_t make_tick();
    in_item_t it;
    it = '0;
    it.func = FUNC_TICK;
    it.seq_num = 18'($urandom());
    it.buffer_handle = 16'($urandom());
    return it;
  endfunction

  // Wait until the block is idle, then write one register.
  task automatic write_reg(logic [2:0] idx, int value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SN_LENGTH:       sn_len_q = value[4:0];
      REG_HEADER_BYTES:    hdr_bytes_q = value[1:0];
      REG_INTEGRITY_CHECK: integ_chk_q = value[0];
      REG_REORDER_ENABLE:  reord_en_q = value[0];
      REG_REORDER_TICKS:   reord_ticks_q = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int snl, int hdr, int integ, int en, int ticks);
    write_reg(REG_SN_LENGTH, snl);
    write_reg(REG_HEADER_BYTES, hdr);
    write_reg(REG_INTEGRITY_CHECK, integ);
    write_reg(REG_REORDER_ENABLE, en);
    write_reg(REG_REORDER_TICKS, ticks);
  endtask

  // Default settings: short drops, in-order and gapped arrivals, duplicates,
  // stale and out-of-window PDUs, and ticks while the timer is idle.
  task automatic test_window_basics();
    send_item(make_pdu(0, 0, 1, 16'h0000));
    send_item(make_pdu(0, 2, 1, 16'hFFFF));
    send_item(make_pdu(0, 3, 1, 16'h1111));
    send_item(make_pdu(2, 9000, 0, 16'h2222));
    send_item(make_pdu(2, 100, 1, 16'h3333));
    send_item(make_pdu(0, 100, 1, 16'h4444));
    send_item(make_pdu(1, 8191, 1, 16'h5555));
    send_item(make_pdu(200, 100, 1, 16'hA5A5));
    send_item(make_pdu(4095, 100, 1, 16'h5A5A));
    send_item(make_pdu(262143, 100, 1, 16'hFFFF));
    send_item(make_tick());
  endtask

  // Integrity checking, timer start, expiry flush and zero duration.
  task automatic test_reorder_timer();
    set_all(18, 0, 1, 1, 2);
    send_item(make_pdu(3, 1, 0, 16'h0BAD));
    send_item(make_pdu(5, 1, 1, 16'h0005));
    send_item(make_pdu(7, 1, 1, 16'h0007));
    send_item(make_tick());
    send_item(make_tick());
    send_item(make_pdu(10, 1, 1, 16'h000A));
    send_item(make_tick());
    send_item(make_tick());
    send_item(make_tick());
    write_reg(REG_REORDER_TICKS, 0);
    send_item(make_pdu(20, 1, 1, 16'h0014));
    send_item(make_tick());
    send_item(make_tick());
  endtask

  // Random traffic around the window: mostly well-formed, some noise.
  task automatic test_random_traffic(int n_items);
    in_item_t it;
    int r;
    int off;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 14) begin
        it = make_tick();
      end else if (r < 24) begin
        it = make_pdu($urandom_range(0, 262143), $urandom_range(0, 16383),
                      $urandom_range(0, 1) != 0, $urandom_range(0, 65535));
      end else begin
        off = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 70) - 6 : $urandom_range(0, 6);
        it = make_pdu(int'(win_deliv) + off,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(4, 9000),
                      $urandom_range(0, 9) != 0, $urandom_range(0, 65535));
      end
      send_item(it);
    end
  endtask

  // Result consumer with random stalls.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind || out_data.count_value !== want.count_value ||
            out_data.handle_out !== want.handle_out || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_SN_LENGTH;
    cfg_wdata = '0;
    idle_on = 1'b1;
    mismatches = 0;
    sn_len_q = 5'd12;
    hdr_bytes_q = 2'd2;
    integ_chk_q = 1'b0;
    reord_en_q = 1'b0;
    reord_ticks_q = 16'd1;
    rx_next = '0;
    win_deliv = '0;
    win_reord = '0;
    wrapped = 1'b0;
    t_running = 1'b0;
    t_left = 0;
    for (int i = 0; i < BufferDepth; i++) begin
      slot_full[i] = 1'b0;
      slot_hdl[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_window_basics();
    test_reorder_timer();
    set_all(12, 2, 0, 1, 3);
    test_random_traffic(50);
    set_all(18, 0, 1, 1, 1);
    test_random_traffic(50);
    set_all(5, 3, 0, 0, 65535);
    test_random_traffic(50);
    set_all(18, 1, 0, 1, 0);
    test_random_traffic(50);
    set_all(31, 0, 1, 1, 65535);
    test_random_traffic(50);
    set_all(12, 3, 1, 1, 2);
    test_random_traffic(50);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
